/* src/good_length_count_dp_unit_macros.svh */
// Assertion macros shared by the good length count unit.
`ifndef GOOD_LENGTH_COUNT_DP_UNIT_MACROS_SVH
`define GOOD_LENGTH_COUNT_DP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLDP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GLDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/gldp_pkg.sv */
// Package with constants and types of the good length count unit.
package gldp_pkg;

    localparam int GLDP_MAX_LEN = 4096;
    localparam int GLDP_IN_W    = 13;
    localparam int GLDP_CNT_W   = 30;

    localparam logic [GLDP_CNT_W-1:0] GLDP_MODULUS = GLDP_CNT_W'(1000000007);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_FINISH,
        ST_DRAIN
    } gldp_state_t;

endpackage

/* src/good_length_count_dp_unit.sv */
// Top level of the good length count unit: sequencer, table and result register.
//
// One request on the s_ channel carries low and high length bounds and two
// run lengths; one transfer on the m_ channel returns the number of good
// strings modulo 1000000007. The high bound saturates at MAX_LEN.
// After a request is taken the table is filled one entry per cycle from the
// top length down to zero: each cycle reads the two entries above the
// current index from the two read ports of the table memory and writes the
// new entry, with the value written in the previous cycle forwarded when a
// read hits it. After the fill the sequencer passes through FINISH, where
// the entry for length zero is captured, and DRAIN, where the result moves
// to the output register; a new request is taken only back in IDLE. The
// fill rate is set by the single write port of the table.
// A finished result waits in the output register while the next request is
// taken; if it is still not taken when the next result is ready, the unit
// holds that result and accepts nothing until the transfer completes.
// Reset returns the sequencer to idle and drops m_valid; table contents are
// not cleared since every request writes the entries it reads.
module good_length_count_dp_unit import gldp_pkg::*; #(
    parameter int MAX_LEN = GLDP_MAX_LEN
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [GLDP_IN_W-1:0]  s_low_len,
    input  logic [GLDP_IN_W-1:0]  s_high_len,
    input  logic [GLDP_IN_W-1:0]  s_zero_run,
    input  logic [GLDP_IN_W-1:0]  s_one_run,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [GLDP_CNT_W-1:0] m_count
);

`include "good_length_count_dp_unit_macros.svh"

    localparam int IW = $clog2(MAX_LEN + 1);
    localparam int SW = ((IW > GLDP_IN_W) ? IW : GLDP_IN_W) + 1;
    localparam logic [SW-1:0] TOP_MAX = SW'(MAX_LEN);

    gldp_state_t state_reg, state_next;

    logic [IW-1:0]         top_reg;
    logic [IW-1:0]         idx_reg;
    logic [GLDP_IN_W-1:0]  lo_reg;
    logic [GLDP_IN_W-1:0]  zr_reg;
    logic [GLDP_IN_W-1:0]  or_reg;

    logic                  rd_vld_reg;
    logic [IW-1:0]         rd_idx_reg;
    logic                  z_ok_reg, o_ok_reg;
    logic                  z_fwd_reg, o_fwd_reg;
    logic                  in_range_reg;
    logic [GLDP_CNT_W-1:0] fwd_data_reg;
    logic [GLDP_CNT_W-1:0] res_reg;
    logic                  m_valid_reg;
    logic [GLDP_CNT_W-1:0] m_count_reg;

    logic                  s_acc;
    logic [SW-1:0]         hi_ext;
    logic [IW-1:0]         top_in;
    logic                  issue;
    logic [SW-1:0]         zj, oj;
    logic                  z_ok, o_ok;
    logic [IW-1:0]         z_addr, o_addr;
    logic                  wr_en;
    logic [GLDP_CNT_W-1:0] wr_data;
    logic [GLDP_CNT_W-1:0] rd_z_data, rd_o_data;
    logic [GLDP_CNT_W-1:0] z_term, o_term;
    logic                  capture;
    logic                  out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign hi_ext  = SW'(s_high_len);
    assign top_in  = (hi_ext > TOP_MAX) ? TOP_MAX[IW-1:0] : hi_ext[IW-1:0];

    assign issue  = (state_reg == ST_FILL);
    assign zj     = SW'(idx_reg) + SW'(zr_reg);
    assign oj     = SW'(idx_reg) + SW'(or_reg);
    assign z_ok   = (zr_reg != '0) && (zj <= SW'(top_reg));
    assign o_ok   = (or_reg != '0) && (oj <= SW'(top_reg));
    assign z_addr = z_ok ? zj[IW-1:0] : '0;
    assign o_addr = o_ok ? oj[IW-1:0] : '0;

    assign wr_en   = rd_vld_reg;
    assign capture = rd_vld_reg && (rd_idx_reg == '0);

    gldp_ram #(
        .DEPTH (MAX_LEN + 1),
        .AW    (IW)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (rd_idx_reg),
        .wr_data   (wr_data),
        .rd_en     (issue),
        .rd_a_addr (z_addr),
        .rd_b_addr (o_addr),
        .rd_a_data (rd_z_data),
        .rd_b_data (rd_o_data)
    );

    assign z_term = z_ok_reg ? (z_fwd_reg ? fwd_data_reg : rd_z_data) : '0;
    assign o_term = o_ok_reg ? (o_fwd_reg ? fwd_data_reg : rd_o_data) : '0;

    gldp_modsum u_modsum (
        .base   (in_range_reg),
        .term_a (z_term),
        .term_b (o_term),
        .sum    (wr_data)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (idx_reg == '0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (state_reg == ST_DRAIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            top_reg <= top_in;
            idx_reg <= top_in;
            lo_reg  <= s_low_len;
            zr_reg  <= s_zero_run;
            or_reg  <= s_one_run;
        end else if (issue && idx_reg != '0) begin
            idx_reg <= idx_reg - IW'(1);
        end
        rd_idx_reg   <= idx_reg;
        z_ok_reg     <= z_ok;
        o_ok_reg     <= o_ok;
        z_fwd_reg    <= wr_en && z_ok && (z_addr == rd_idx_reg);
        o_fwd_reg    <= wr_en && o_ok && (o_addr == rd_idx_reg);
        in_range_reg <= SW'(idx_reg) >= SW'(lo_reg);
        fwd_data_reg <= wr_data;
        if (capture) begin
            res_reg <= wr_data;
        end
        if (state_reg == ST_DRAIN && out_free) begin
            m_count_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_count = m_count_reg;

    `GLDP_ASSERT_NEXT(a_accept_starts_fill, aclk, aresetn, s_valid && s_ready,
                      state_reg == ST_FILL, "Accepted request did not start the fill")
    `GLDP_ASSERT_NOW(a_write_in_fill, aclk, aresetn, rd_vld_reg,
                     state_reg == ST_FILL || state_reg == ST_FINISH,
                     "Table write outside of the fill")
    `GLDP_ASSERT_NOW(a_fwd_needs_write, aclk, aresetn, z_fwd_reg || o_fwd_reg,
                     rd_vld_reg && $past(rd_vld_reg), "Forwarding without a preceding write")
    `GLDP_ASSERT_NEXT(a_finish_captures, aclk, aresetn, state_reg == ST_FINISH,
                      state_reg == ST_DRAIN && $past(capture), "Final entry was not captured")

endmodule

/* src/gldp_ram.sv */
// Table memory with one write port and two registered read ports.
module gldp_ram import gldp_pkg::*; #(
    parameter int DEPTH = GLDP_MAX_LEN + 1,
    parameter int AW    = $clog2(GLDP_MAX_LEN + 1)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [GLDP_CNT_W-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_a_addr,
    input  logic [AW-1:0]         rd_b_addr,
    output logic [GLDP_CNT_W-1:0] rd_a_data,
    output logic [GLDP_CNT_W-1:0] rd_b_data
);

    logic [GLDP_CNT_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_data <= mem[rd_a_addr];
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule

/* src/gldp_modsum.sv */
// Modular sum of a one-bit base and two reduced table terms.
module gldp_modsum import gldp_pkg::*; (
    input  logic                  base,
    input  logic [GLDP_CNT_W-1:0] term_a,
    input  logic [GLDP_CNT_W-1:0] term_b,
    output logic [GLDP_CNT_W-1:0] sum
);

    logic [GLDP_CNT_W:0] raw;
    logic [GLDP_CNT_W:0] red;

    // Both terms are below the modulus, so one subtraction is enough.
    assign raw = (GLDP_CNT_W+1)'(term_a) + (GLDP_CNT_W+1)'(term_b)
               + (GLDP_CNT_W+1)'(base);
    assign red = raw - (GLDP_CNT_W+1)'(GLDP_MODULUS);
    assign sum = (raw >= (GLDP_CNT_W+1)'(GLDP_MODULUS)) ? red[GLDP_CNT_W-1:0]
                                                        : raw[GLDP_CNT_W-1:0];

endmodule
